>>> rtl/smart_card_atr_parser_top_macros.svh
// Assertion macros for the smart card ATR parser.
// Used by smart_card_atr_parser_top; expects clk and rst_n in scope.
`ifndef SMART_CARD_ATR_PARSER_TOP_MACROS_SVH
`define SMART_CARD_ATR_PARSER_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ATR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

>>> rtl/atr_pkg.sv
// Types and constants for the smart card ATR parser.
// No dependencies; imported by smart_card_atr_parser_top.
package atr_pkg;

    localparam int MAX_ATR_BYTES_DEF = 33;
    localparam int NUM_PARAMS        = 14;
    localparam logic [7:0] IMPLICIT_FIDI_RST = 8'd17;

    localparam logic [7:0] TS_DIRECT  = 8'h3B;
    localparam logic [7:0] TS_INVERSE = 8'h03;
    localparam logic [3:0] BWI_LIMIT  = 4'hA;
    localparam logic [3:0] T_MAX      = 4'hF;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_T0    = 3'd1,
        PH_IFACE = 3'd2,
        PH_HIST  = 3'd3,
        PH_TCK   = 3'd4
    } phase_t;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD_TS = 3'd1;
    localparam logic [2:0] ST_RX_ERR = 3'd2;
    localparam logic [2:0] ST_BAD_LEN = 3'd3;
    localparam logic [2:0] ST_BAD_TCK = 3'd4;

    localparam logic [3:0] PC_CONV      = 4'd0;
    localparam logic [3:0] PC_LENGTH    = 4'd1;
    localparam logic [3:0] PC_T         = 4'd2;
    localparam logic [3:0] PC_SPECIFIC  = 4'd3;
    localparam logic [3:0] PC_FIDI      = 4'd4;
    localparam logic [3:0] PC_N         = 4'd5;
    localparam logic [3:0] PC_WI        = 4'd6;
    localparam logic [3:0] PC_IFSC      = 4'd7;
    localparam logic [3:0] PC_BWI       = 4'd8;
    localparam logic [3:0] PC_CWI       = 4'd9;
    localparam logic [3:0] PC_CHECK     = 4'd10;
    localparam logic [3:0] PC_CLOCKSTOP = 4'd11;
    localparam logic [3:0] PC_CLASS     = 4'd12;
    localparam logic [3:0] PC_C6        = 4'd13;

    // Entries of the T=15 group store.
    localparam logic SLOT_T15_TA = 1'b0;
    localparam logic SLOT_T15_TB = 1'b1;

    localparam logic [3:0] IF_TA = 4'b0001;
    localparam logic [3:0] IF_TB = 4'b0010;
    localparam logic [3:0] IF_TC = 4'b0100;

endpackage

>>> rtl/smart_card_atr_parser_top.sv
// Smart card ATR parser: top level with parse control and parameter stores.
// Depends on atr_pkg and smart_card_atr_parser_top_macros.svh.
// Usage: ATR bytes are taken one per cycle while an ATR is being parsed. When the ATR ends or an
// error stops it, a run of 14 parameter results (codes 0 to 13, tlast on code 13) is read out of
// the parameter store, one result per cycle unless the output stalls, via the emit counter, the
// read stage and the output register. The input is held off after the final byte until every
// code has been read; output stalls stretch the run. The user must write the implicit FiDi
// register only while no request or result is in flight; the block does not enforce this.
`include "smart_card_atr_parser_top_macros.svh"

module smart_card_atr_parser_top #(
    parameter int MAX_ATR_BYTES = atr_pkg::MAX_ATR_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // rx_error, start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // param_code, param_value, param_present, status
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata       // implicit FiDi
);
    import atr_pkg::*;

    localparam int CNT_W = $clog2(MAX_ATR_BYTES + 1);

    logic [7:0]            mem_a [NUM_PARAMS];
    logic [7:0]            mem_b [2];

    phase_t                phase_reg, phase_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [3:0]            mask_reg, mask_next;
    logic [3:0]            group_reg, group_next;
    logic [3:0]            hist_reg, hist_next;
    logic                  tck_reg, tck_next;
    logic [7:0]            xor_reg, xor_next;
    logic [3:0]            last_t_reg, last_t_next;
    logic                  chain_ok_reg, chain_ok_next;
    logic                  t15_reg, t15_next;
    logic [7:0]            ta2_reg, ta2_next;
    logic [NUM_PARAMS-1:0] valid_reg, valid_next;
    logic [7:0]            implicit_fidi_reg;
    logic [2:0]            status_reg, status_next;
    logic                  emit_busy_reg, emit_busy_next;
    logic [3:0]            emit_cnt_reg, emit_cnt_next;
    logic                  rd_valid_reg;
    logic [3:0]            rd_code_reg;
    logic [7:0]            a_rdata_reg;
    logic [7:0]            b_rdata_reg;
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;
    logic                  out_last_reg;

    logic                  in_fire;
    logic                  fire;
    logic                  check;
    logic                  adv;
    logic                  run_busy;
    logic                  mem_a_we;
    logic [3:0]            mem_a_addr;
    logic [7:0]            mem_a_wdata;
    logic                  mem_b_we;
    logic                  mem_b_addr;
    logic [3:0]            rd_a_addr;
    logic                  rd_b_addr;
    logic [7:0]            res_value;
    logic                  res_present;
    logic [7:0]            rx_byte;
    logic [3:0]            td_t;

    assign rx_byte       = s_axis_tdata;
    assign td_t          = rx_byte[3:0];
    assign run_busy      = emit_busy_reg || rd_valid_reg;
    assign s_axis_tready = !run_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign adv           = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        mask_next     = mask_reg;
        group_next    = group_reg;
        hist_next     = hist_reg;
        tck_next      = tck_reg;
        xor_next      = xor_reg;
        last_t_next   = last_t_reg;
        chain_ok_next = chain_ok_reg;
        t15_next      = t15_reg;
        ta2_next      = ta2_reg;
        valid_next    = valid_reg;
        status_next   = status_reg;
        mem_a_we      = 1'b0;
        mem_a_addr    = PC_CONV;
        mem_a_wdata   = rx_byte;
        mem_b_we      = 1'b0;
        mem_b_addr    = SLOT_T15_TA;
        fire          = 1'b0;
        check         = 1'b0;

        if (in_fire)
        begin
            if (s_axis_tuser[1])
            begin
                valid_next    = '0;
                count_next    = CNT_W'(1);
                mask_next     = '0;
                group_next    = '0;
                hist_next     = '0;
                tck_next      = 1'b0;
                xor_next      = '0;
                last_t_next   = '0;
                chain_ok_next = 1'b1;
                t15_next      = 1'b0;
                ta2_next      = '0;
                phase_next    = PH_T0;
                if (rx_byte == TS_INVERSE)
                begin
                    mem_a_we            = 1'b1;
                    mem_a_wdata         = 8'd1;
                    valid_next[PC_CONV] = 1'b1;
                end
                else if (rx_byte == TS_DIRECT && !s_axis_tuser[0])
                begin
                    mem_a_we            = 1'b1;
                    mem_a_wdata         = 8'd0;
                    valid_next[PC_CONV] = 1'b1;
                end
                else
                begin
                    fire        = 1'b1;
                    status_next = ST_BAD_TS;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                if (s_axis_tuser[0])
                begin
                    fire        = 1'b1;
                    status_next = ST_RX_ERR;
                end
                else if (count_reg >= CNT_W'(MAX_ATR_BYTES))
                begin
                    fire        = 1'b1;
                    status_next = ST_BAD_LEN;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    xor_next   = xor_reg ^ rx_byte;
                    unique case (phase_reg)
                        PH_T0:
                        begin
                            mask_next  = rx_byte[7:4];
                            hist_next  = rx_byte[3:0];
                            group_next = 4'd1;
                            check      = 1'b1;
                        end
                        PH_IFACE:
                        begin
                            check = 1'b1;
                            priority if (mask_reg[0])
                            begin
                                mask_next = mask_reg & ~IF_TA;
                                if (group_reg == 4'd1)
                                begin
                                    mem_a_we            = 1'b1;
                                    mem_a_addr          = PC_FIDI;
                                    valid_next[PC_FIDI] = 1'b1;
                                end
                                if (group_reg == 4'd2)
                                begin
                                    ta2_next                = rx_byte;
                                    valid_next[PC_SPECIFIC] = 1'b1;
                                end
                                if (group_reg == 4'd3)
                                begin
                                    mem_a_we            = 1'b1;
                                    mem_a_addr          = PC_IFSC;
                                    valid_next[PC_IFSC] = 1'b1;
                                end
                                if (t15_reg)
                                begin
                                    mem_b_we                 = 1'b1;
                                    mem_b_addr               = SLOT_T15_TA;
                                    valid_next[PC_CLOCKSTOP] = 1'b1;
                                    valid_next[PC_CLASS]     = 1'b1;
                                end
                            end
                            else if (mask_reg[1])
                            begin
                                mask_next = mask_reg & ~IF_TB;
                                if (group_reg == 4'd3)
                                begin
                                    mem_a_we           = 1'b1;
                                    mem_a_addr         = PC_BWI;
                                    valid_next[PC_CWI] = 1'b1;
                                    if (rx_byte[7:4] < BWI_LIMIT)
                                    begin
                                        valid_next[PC_BWI] = 1'b1;
                                    end
                                end
                                if (t15_reg)
                                begin
                                    mem_b_we          = 1'b1;
                                    mem_b_addr        = SLOT_T15_TB;
                                    valid_next[PC_C6] = 1'b1;
                                end
                            end
                            else if (mask_reg[2])
                            begin
                                mask_next = mask_reg & ~IF_TC;
                                if (group_reg == 4'd1)
                                begin
                                    mem_a_we         = 1'b1;
                                    mem_a_addr       = PC_N;
                                    valid_next[PC_N] = 1'b1;
                                end
                                if (group_reg == 4'd2 && rx_byte != 8'd0)
                                begin
                                    mem_a_we          = 1'b1;
                                    mem_a_addr        = PC_WI;
                                    valid_next[PC_WI] = 1'b1;
                                end
                                if (group_reg == 4'd3)
                                begin
                                    mem_a_we             = 1'b1;
                                    mem_a_addr           = PC_CHECK;
                                    valid_next[PC_CHECK] = 1'b1;
                                end
                            end
                            else
                            begin
                                if (td_t != 4'd0)
                                begin
                                    tck_next = 1'b1;
                                end
                                t15_next = 1'b0;
                                if (group_reg == 4'd1)
                                begin
                                    mem_a_we         = 1'b1;
                                    mem_a_addr       = PC_T;
                                    mem_a_wdata      = {4'd0, td_t};
                                    valid_next[PC_T] = 1'b1;
                                    last_t_next      = td_t;
                                end
                                else if (chain_ok_reg)
                                begin
                                    if (td_t >= last_t_reg)
                                    begin
                                        last_t_next = td_t;
                                        if (td_t == T_MAX)
                                        begin
                                            t15_next                 = 1'b1;
                                            valid_next[PC_CLOCKSTOP] = 1'b0;
                                            valid_next[PC_CLASS]     = 1'b0;
                                            valid_next[PC_C6]        = 1'b0;
                                        end
                                    end
                                    else
                                    begin
                                        chain_ok_next = 1'b0;
                                    end
                                end
                                mask_next = rx_byte[7:4];
                                if (group_reg != T_MAX)
                                begin
                                    group_next = group_reg + 1'b1;
                                end
                            end
                        end
                        PH_HIST:
                        begin
                            if (hist_reg != 4'd0)
                            begin
                                hist_next = hist_reg - 1'b1;
                            end
                            check = 1'b1;
                        end
                        PH_TCK:
                        begin
                            fire        = 1'b1;
                            status_next = ((xor_reg ^ rx_byte) != 8'd0) ? ST_BAD_TCK : ST_OK;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (check)
                    begin
                        priority if (mask_next != 4'd0)
                        begin
                            phase_next = PH_IFACE;
                        end
                        else if (hist_next != 4'd0)
                        begin
                            phase_next = PH_HIST;
                        end
                        else if (tck_next)
                        begin
                            phase_next = PH_TCK;
                        end
                        else
                        begin
                            fire        = 1'b1;
                            status_next = ST_OK;
                        end
                    end
                end
            end
        end
        if (fire)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        emit_busy_next = emit_busy_reg;
        emit_cnt_next  = emit_cnt_reg;
        if (fire)
        begin
            emit_busy_next = 1'b1;
            emit_cnt_next  = PC_CONV;
        end
        else if (adv && emit_busy_reg)
        begin
            emit_cnt_next = emit_cnt_reg + 1'b1;
            if (emit_cnt_reg == PC_C6)
            begin
                emit_busy_next = 1'b0;
                emit_cnt_next  = PC_CONV;
            end
        end
    end

    // Codes that share a stored byte read the entry of their partner code.
    assign rd_a_addr = (emit_cnt_reg == PC_CWI) ? PC_BWI : emit_cnt_reg;
    assign rd_b_addr = (emit_cnt_reg == PC_C6) ? SLOT_T15_TB : SLOT_T15_TA;

    always_comb
    begin
        res_present = valid_reg[rd_code_reg];
        res_value   = 8'd0;
        unique case (rd_code_reg)
            PC_CONV, PC_N, PC_WI, PC_IFSC:
            begin
                res_value = res_present ? a_rdata_reg : 8'd0;
            end
            PC_LENGTH:
            begin
                res_present = 1'b1;
                res_value   = 8'(count_reg);
            end
            PC_T:
            begin
                res_value   = res_present ? a_rdata_reg : 8'd0;
                res_present = 1'b1;
                if (valid_reg[PC_SPECIFIC] && ta2_reg[3:0] < 4'd2)
                begin
                    res_value = {4'd0, ta2_reg[3:0]};
                end
            end
            PC_SPECIFIC:
            begin
                res_present = 1'b1;
                res_value   = {7'd0, valid_reg[PC_SPECIFIC]};
            end
            PC_FIDI:
            begin
                if (res_present)
                begin
                    res_value = (valid_reg[PC_SPECIFIC] && ta2_reg[4]) ? implicit_fidi_reg
                                                                      : a_rdata_reg;
                end
            end
            PC_BWI:
            begin
                res_value = res_present ? {4'd0, a_rdata_reg[7:4]} : 8'd0;
            end
            PC_CWI:
            begin
                res_value = res_present ? {4'd0, a_rdata_reg[3:0]} : 8'd0;
            end
            PC_CHECK:
            begin
                res_value = res_present ? {7'd0, a_rdata_reg[0]} : 8'd0;
            end
            PC_CLOCKSTOP:
            begin
                res_value = res_present ? {6'd0, b_rdata_reg[7:6]} : 8'd0;
            end
            PC_CLASS:
            begin
                res_value = res_present ? {2'd0, b_rdata_reg[5:0]} : 8'd0;
            end
            PC_C6:
            begin
                if (res_present && b_rdata_reg != 8'd0)
                begin
                    res_value = b_rdata_reg[7] ? 8'd2 : 8'd1;
                end
            end
            default:
            begin
                res_present = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            count_reg         <= '0;
            mask_reg          <= '0;
            group_reg         <= '0;
            hist_reg          <= '0;
            tck_reg           <= 1'b0;
            xor_reg           <= '0;
            last_t_reg        <= '0;
            chain_ok_reg      <= 1'b1;
            t15_reg           <= 1'b0;
            ta2_reg           <= '0;
            valid_reg         <= '0;
            implicit_fidi_reg <= IMPLICIT_FIDI_RST;
            status_reg        <= ST_OK;
            emit_busy_reg     <= 1'b0;
            emit_cnt_reg      <= PC_CONV;
            rd_valid_reg      <= 1'b0;
            rd_code_reg       <= PC_CONV;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            mask_reg      <= mask_next;
            group_reg     <= group_next;
            hist_reg      <= hist_next;
            tck_reg       <= tck_next;
            xor_reg       <= xor_next;
            last_t_reg    <= last_t_next;
            chain_ok_reg  <= chain_ok_next;
            t15_reg       <= t15_next;
            ta2_reg       <= ta2_next;
            valid_reg     <= valid_next;
            status_reg    <= status_next;
            emit_busy_reg <= emit_busy_next;
            emit_cnt_reg  <= emit_cnt_next;
            if (cfg_we)
            begin
                implicit_fidi_reg <= cfg_wdata;
            end
            if (adv)
            begin
                rd_valid_reg  <= emit_busy_reg;
                rd_code_reg   <= emit_cnt_reg;
                out_valid_reg <= rd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_a_we)
        begin
            mem_a[mem_a_addr] <= mem_a_wdata;
        end
        if (mem_b_we)
        begin
            mem_b[mem_b_addr] <= rx_byte;
        end
        if (adv)
        begin
            a_rdata_reg  <= mem_a[rd_a_addr];
            b_rdata_reg  <= mem_b[rd_b_addr];
            out_data_reg <= {status_reg, res_present, res_value, rd_code_reg};
            out_last_reg <= (rd_code_reg == PC_C6);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `ATR_ASSERT(a_no_write_in_run, (mem_a_we || mem_b_we) |-> !run_busy, "store written in a run")
    `ATR_ASSERT(a_run_start, $rose(emit_busy_reg) |-> emit_cnt_reg == PC_CONV, "bad run start")
    `ATR_ASSERT(a_code_in_range, emit_busy_reg |-> emit_cnt_reg <= PC_C6, "run code out of range")

endmodule

>>> tb/sv/smart_card_atr_parser_top_test.sv
// Self-checking testbench for smart_card_atr_parser_top: drives ATR byte requests and
// checks every parameter result against a built-in parser model.
// Depends on atr_pkg and the smart_card_atr_parser_top RTL.
module smart_card_atr_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atr_pkg::*;

    localparam int ATR_MAX         = MAX_ATR_BYTES_DEF;
    localparam int DRAIN_CYCLES    = 24;
    localparam int END_CYCLES      = 40;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_MARK_A     = 120;
    localparam int HOLD_MARK_B     = 360;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_REQUESTS  = 140;

    localparam logic [7:0] CONV_DIRECT    = 8'd0;
    localparam logic [7:0] CONV_INVERSE   = 8'd1;
    localparam logic [7:0] C6_NOT_USED    = 8'd0;
    localparam logic [7:0] C6_STANDARD    = 8'd1;
    localparam logic [7:0] C6_PROPRIETARY = 8'd2;
    localparam logic [3:0] T_OVERRIDE_LIM = 4'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       start;
    } atr_req_t;

    typedef struct packed {
        logic [3:0] code;
        logic [7:0] value;
        logic       present;
        logic [2:0] status;
        logic       last;
    } atr_param_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    smart_card_atr_parser_top #(
        .MAX_ATR_BYTES(ATR_MAX)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),    // rx_byte
        .s_axis_tuser  (s_tuser),    // rx_error, start_req
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata), // param_code, param_value, param_present, status
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)   // implicit FiDi
    );

    // Parser model state.
    phase_t     atr_phase;
    logic [5:0] atr_count;
    logic [3:0] atr_mask;
    logic [3:0] atr_group;
    logic [3:0] atr_hist;
    logic       atr_tck;
    logic [7:0] atr_xor;
    logic [3:0] atr_last_t;
    logic       atr_chain_ok;
    logic       atr_t15;
    logic [7:0] atr_ta2;
    logic [7:0] atr_fidi;
    logic [7:0] pv_value [NUM_PARAMS];
    logic       pv_valid [NUM_PARAMS];

    atr_req_t   atr_tx_q [$];
    atr_param_t expected_params [$];

    int  items_queued = 0;
    int  items_taken = 0;
    int  stim_count = 0;
    int  results_taken = 0;
    int  mismatches = 0;
    int  fidi_writes = 0;
    int  runs_by_status [8];
    int  idle_cycles = 0;
    logic in_taken = 1'b0;

    int  gap_left = 0;
    int  burst_left = 0;
    int  hold_left = 0;
    int  holds_done = 0;
    int  mode_left = 0;
    int  rx_mode = 0;
    logic [7:0] stall_pat = 8'hFF;

    function automatic void store_param(input logic [3:0] code, input logic [7:0] v);
        pv_value[code] = v;
        pv_valid[code] = 1'b1;
    endfunction

    function automatic void open_atr();
        for (int k = 0; k < NUM_PARAMS; k++)
        begin
            pv_value[k] = 8'd0;
            pv_valid[k] = 1'b0;
        end
        atr_count    = 6'd1;
        atr_mask     = 4'd0;
        atr_group    = 4'd0;
        atr_hist     = 4'd0;
        atr_tck      = 1'b0;
        atr_xor      = 8'd0;
        atr_last_t   = 4'd0;
        atr_chain_ok = 1'b1;
        atr_t15      = 1'b0;
        atr_ta2      = 8'd0;
    endfunction

    function automatic void report_params(input logic [2:0] st);
        logic [7:0] v;
        logic       p;
        atr_param_t e;
        for (int k = 0; k < NUM_PARAMS; k++)
        begin
            v = pv_valid[k] ? pv_value[k] : 8'd0;
            p = pv_valid[k];
            if (k == PC_LENGTH)
            begin
                v = {2'b00, atr_count};
                p = 1'b1;
            end
            else if (k == PC_T)
            begin
                if (pv_valid[PC_SPECIFIC] && atr_ta2[3:0] < T_OVERRIDE_LIM)
                    v = {4'd0, atr_ta2[3:0]};
                p = 1'b1;
            end
            else if (k == PC_SPECIFIC)
            begin
                v = {7'd0, pv_valid[PC_SPECIFIC]};
                p = 1'b1;
            end
            else if (k == PC_FIDI && p && pv_valid[PC_SPECIFIC] && atr_ta2[4])
            begin
                v = atr_fidi;
            end
            e.code    = 4'(k);
            e.value   = v;
            e.present = p;
            e.status  = st;
            e.last    = (k == NUM_PARAMS - 1);
            expected_params.push_back(e);
        end
        atr_phase = PH_IDLE;
    endfunction

    function automatic void advance_phase();
        if (atr_mask != 4'd0)
            atr_phase = PH_IFACE;
        else if (atr_hist != 4'd0)
            atr_phase = PH_HIST;
        else if (atr_tck)
            atr_phase = PH_TCK;
        else
            report_params(ST_OK);
    endfunction

    function automatic void take_iface_byte(input logic [7:0] b);
        logic [3:0] g;
        logic [3:0] m;
        logic [3:0] t;
        g = atr_group;
        m = atr_mask;
        if (m & IF_TA)
        begin
            atr_mask = m & 4'hE;
            if (g == 4'd1)
                store_param(PC_FIDI, b);
            if (g == 4'd2)
            begin
                atr_ta2 = b;
                store_param(PC_SPECIFIC, 8'd1);
            end
            if (g == 4'd3)
                store_param(PC_IFSC, b);
            if (atr_t15)
            begin
                store_param(PC_CLOCKSTOP, {6'd0, b[7:6]});
                store_param(PC_CLASS, {2'd0, b[5:0]});
            end
        end
        else if (m & IF_TB)
        begin
            atr_mask = m & 4'hC;
            if (g == 4'd3)
            begin
                if (b[7:4] < BWI_LIMIT)
                    store_param(PC_BWI, {4'd0, b[7:4]});
                store_param(PC_CWI, {4'd0, b[3:0]});
            end
            if (atr_t15)
                store_param(PC_C6, (b == 8'd0) ? C6_NOT_USED :
                                   (b[7] ? C6_PROPRIETARY : C6_STANDARD));
        end
        else if (m & IF_TC)
        begin
            atr_mask = m & 4'h8;
            if (g == 4'd1)
                store_param(PC_N, b);
            if (g == 4'd2 && b != 8'd0)
                store_param(PC_WI, b);
            if (g == 4'd3)
                store_param(PC_CHECK, {7'd0, b[0]});
        end
        else
        begin
            t = b[3:0];
            if (t != 4'd0)
                atr_tck = 1'b1;
            atr_t15 = 1'b0;
            if (g == 4'd1)
            begin
                store_param(PC_T, {4'd0, t});
                atr_last_t = t;
            end
            else if (atr_chain_ok)
            begin
                if (t >= atr_last_t)
                begin
                    atr_last_t = t;
                    if (t == T_MAX)
                    begin
                        atr_t15 = 1'b1;
                        pv_valid[PC_CLOCKSTOP] = 1'b0;
                        pv_valid[PC_CLASS] = 1'b0;
                        pv_valid[PC_C6] = 1'b0;
                    end
                end
                else
                begin
                    atr_chain_ok = 1'b0;
                end
            end
            atr_mask = b[7:4];
            if (atr_group < 4'd15)
                atr_group = atr_group + 4'd1;
        end
    endfunction

    function automatic void parse_atr_byte(input atr_req_t r);
        if (r.start)
        begin
            open_atr();
            if (r.data == TS_INVERSE)
            begin
                store_param(PC_CONV, CONV_INVERSE);
                atr_phase = PH_T0;
            end
            else if (r.data == TS_DIRECT && !r.err)
            begin
                store_param(PC_CONV, CONV_DIRECT);
                atr_phase = PH_T0;
            end
            else
            begin
                report_params(ST_BAD_TS);
            end
        end
        else if (atr_phase != PH_IDLE)
        begin
            if (r.err)
                report_params(ST_RX_ERR);
            else if (atr_count >= ATR_MAX)
                report_params(ST_BAD_LEN);
            else
            begin
                atr_count = atr_count + 6'd1;
                atr_xor = atr_xor ^ r.data;
                case (atr_phase)
                    PH_T0:
                    begin
                        atr_mask = r.data[7:4];
                        atr_hist = r.data[3:0];
                        atr_group = 4'd1;
                        advance_phase();
                    end
                    PH_IFACE:
                    begin
                        take_iface_byte(r.data);
                        advance_phase();
                    end
                    PH_HIST:
                    begin
                        if (atr_hist != 4'd0)
                            atr_hist = atr_hist - 4'd1;
                        advance_phase();
                    end
                    default:
                        report_params((atr_xor != 8'd0) ? ST_BAD_TCK : ST_OK);
                endcase
            end
        end
    endfunction

    function automatic void queue_req(input logic [7:0] data, input logic err,
                                      input logic start, input bit counted);
        atr_req_t r;
        r.data = data;
        r.err = err;
        r.start = start;
        atr_tx_q.push_back(r);
        items_queued++;
        if (counted)
            stim_count++;
    endfunction

    function automatic logic [7:0] rand_field_byte();
        return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    endfunction

    function automatic void queue_random_atr(input bit long_atr);
        logic [7:0] body [$];
        logic [7:0] ts;
        logic [7:0] chk;
        logic [7:0] b;
        logic [3:0] y;
        logic [3:0] y_next;
        logic [3:0] t;
        logic       ts_err;
        int         hist;
        int         groups;
        int         cut;
        int         fault;
        bit         need_tck;
        if (long_atr)
            hist = 15;
        else if ($urandom_range(0, 3) == 0)
            hist = $urandom_range(0, 15);
        else
            hist = $urandom_range(0, 4);
        groups = long_atr ? 4 : $urandom_range(0, 4);
        y = long_atr ? 4'h7 : 4'($urandom_range(0, 7));
        y[3] = (groups > 0);
        need_tck = 1'b0;
        body.push_back({y, 4'(hist)});
        for (int g = 1; g <= groups + 1; g++)
        begin
            if (y[0])
            begin
                b = rand_field_byte();
                if (g == 2 && $urandom_range(0, 1) == 1)
                    b[3:0] = 4'($urandom_range(0, 1));
                body.push_back(b);
            end
            if (y[1])
                body.push_back(rand_field_byte());
            if (y[2])
                body.push_back(rand_field_byte());
            if (y[3])
            begin
                case ($urandom_range(0, 4))
                    0: t = 4'h0;
                    1: t = 4'h1;
                    2: t = T_MAX;
                    3: t = 4'hE;
                    default: t = 4'($urandom_range(0, 15));
                endcase
                y_next = long_atr ? 4'h7 : 4'($urandom_range(0, 7));
                y_next[3] = (g < groups);
                if (t != 4'd0)
                    need_tck = 1'b1;
                body.push_back({y_next, t});
                y = y_next;
            end
        end
        for (int i = 0; i < hist; i++)
            body.push_back(8'($urandom_range(0, 255)));
        if (need_tck)
        begin
            chk = 8'd0;
            foreach (body[i])
                chk = chk ^ body[i];
            if ($urandom_range(0, 7) == 0)
                chk = chk ^ 8'($urandom_range(1, 255));
            body.push_back(chk);
        end

        ts_err = 1'b0;
        case ($urandom_range(0, 9))
            7, 8: ts = TS_INVERSE;
            9:
            begin
                ts = TS_INVERSE;
                ts_err = 1'b1;
            end
            default: ts = TS_DIRECT;
        endcase
        fault = long_atr ? 9 : $urandom_range(0, 9);
        cut = $urandom_range(0, body.size() - 1);
        queue_req(ts, ts_err, 1'b1, 1'b1);
        for (int i = 0; i < body.size(); i++)
        begin
            if (fault == 0 && i == cut)
            begin
                queue_req(body[i], 1'b1, 1'b0, 1'b1);
                break;
            end
            if (fault == 1 && i == cut)
                break;
            queue_req(body[i], 1'b0, 1'b0, 1'b1);
        end
    endfunction

    task automatic fill_random_requests(input int count);
        int stop_at;
        stop_at = stim_count + count;
        queue_random_atr(1'b1);
        while (stim_count < stop_at)
        begin
            case ($urandom_range(0, 19))
                0: queue_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
                1: queue_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
                default: queue_random_atr(1'b0);
            endcase
        end
    endtask

    // Waits until every request is taken, closes an open ATR, and lets the result run finish.
    task automatic settle_block(input int extra);
        while (items_taken != items_queued)
            @(negedge clk);
        if (atr_phase != PH_IDLE)
        begin
            @(posedge clk);
            queue_req(8'h00, 1'b0, 1'b1, 1'b1);
            while (items_taken != items_queued)
                @(negedge clk);
        end
        while (expected_params.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_implicit_fidi(input logic [7:0] val);
        settle_block(DRAIN_CYCLES);
        cfg_we = 1'b1;
        cfg_wdata = val;
        atr_fidi = val;
        @(negedge clk);
        cfg_we = 1'b0;
        fidi_writes++;
        @(posedge clk);
    endtask

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        logic [7:0] full_atr [14];
        full_atr = '{8'h3B, 8'hF1, 8'h95, 8'h00, 8'hFF, 8'hF1, 8'h11,
                     8'h00, 8'h0A, 8'h3F, 8'hC3, 8'h45, 8'h80, 8'h48};
        open_atr();
        atr_phase = PH_IDLE;
        atr_count = 6'd0;
        atr_fidi = IMPLICIT_FIDI_RST;
        foreach (runs_by_status[i])
            runs_by_status[i] = 0;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        queue_req(8'h00, 1'b0, 1'b1, 1'b1);
        queue_req(TS_DIRECT, 1'b1, 1'b1, 1'b1);
        queue_req(TS_INVERSE, 1'b1, 1'b1, 1'b1);
        queue_req(8'h00, 1'b0, 1'b0, 1'b1);
        queue_req(8'hFF, 1'b0, 1'b0, 1'b0);
        foreach (full_atr[i])
            queue_req(full_atr[i], 1'b0, (i == 0), 1'b1);
        queue_req(TS_DIRECT, 1'b0, 1'b1, 1'b1);
        queue_req(8'h80, 1'b0, 1'b0, 1'b1);
        queue_req(8'h00, 1'b1, 1'b0, 1'b1);
        queue_req(TS_DIRECT, 1'b0, 1'b1, 1'b1);
        queue_req(8'h12, 1'b0, 1'b0, 1'b1);
        queue_req(TS_DIRECT, 1'b0, 1'b1, 1'b1);
        queue_req(8'h00, 1'b0, 1'b0, 1'b1);

        write_implicit_fidi(8'hFF);
        fill_random_requests(PHASE_REQUESTS);
        write_implicit_fidi(8'h00);
        fill_random_requests(PHASE_REQUESTS);
        write_implicit_fidi(8'($urandom_range(1, 254)));
        fill_random_requests(PHASE_REQUESTS);

        settle_block(END_CYCLES);
        $display("covered %0d requests, %0d results, %0d implicit FiDi settings",
                 stim_count, results_taken, fidi_writes);
        $display("runs by status: ok %0d, bad TS %0d, rx error %0d, length %0d, TCK %0d",
                 runs_by_status[ST_OK], runs_by_status[ST_BAD_TS],
                 runs_by_status[ST_RX_ERR], runs_by_status[ST_BAD_LEN],
                 runs_by_status[ST_BAD_TCK]);
        if (mismatches == 0 && expected_params.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    always @(negedge clk)
    begin
        atr_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (atr_tx_q.size() != 0)
            begin
                req = atr_tx_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= req.data;
                s_tuser <= {req.start, req.err};
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                              : $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
                end
                else
                begin
                    burst_left = burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (holds_done < 2 && m_axis_tvalid &&
                 items_taken >= ((holds_done == 0) ? HOLD_MARK_A : HOLD_MARK_B))
        begin
            hold_left = LONG_HOLD;
            holds_done++;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
                stall_pat = 8'($urandom_range(1, 255));
            end
            else
            begin
                mode_left = mode_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= 1'($urandom_range(0, 1));
                default:
                begin
                    m_tready <= stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[7:1]};
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        atr_param_t got;
        atr_param_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_axis_tready;
            if (s_tvalid && s_axis_tready)
            begin
                parse_atr_byte({s_tdata, s_tuser[0], s_tuser[1]});
                items_taken++;
            end
            if (m_axis_tvalid && m_tready)
            begin
                got.code    = m_axis_tdata[3:0];
                got.value   = m_axis_tdata[11:4];
                got.present = m_axis_tdata[12];
                got.status  = m_axis_tdata[15:13];
                got.last    = m_axis_tlast;
                results_taken++;
                if (got.last === 1'b1 && got.status <= ST_BAD_TCK)
                    runs_by_status[got.status]++;
                if (expected_params.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: code %0d value %h present %b status %0d %s %b",
                                 got.code, got.value, got.present, got.status, "last",
                                 got.last);
                end
                else
                begin
                    want = expected_params.pop_front();
                    if (got.code !== want.code || got.value !== want.value ||
                        got.present !== want.present || got.status !== want.status ||
                        got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("mismatch: expected code %0d value %h present %b %s",
                                     want.code, want.value, want.present, "status/last");
                            $display("    expected %0d/%b, got code %0d value %h present %b",
                                     want.status, want.last, got.code, got.value, got.present);
                            $display("    got status/last %0d/%b", got.status, got.last);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
